// ===== hdl/ole_pkg.sv =====
// ----------------------------------------------------------------------------
// ole_pkg
// Shared widths, codes and sequencer states for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

    // Field widths of the request and response words
    localparam int CMD_W      = 2;
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 8;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 5;

    // Default list capacity
    localparam int CAPACITY_DEF = 16;

    // Request commands
    typedef enum logic [CMD_W-1:0] {
        CMD_INS_FRONT = 2'd0,
        CMD_INS_END   = 2'd1,
        CMD_DEL_LAST  = 2'd2,
        CMD_DEL_POS   = 2'd3
    } cmd_t;

    // Response status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_SMALL  = 3'd2,
        ST_BEYOND = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_TAKE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_FINISH
    } state_t;

endpackage

// ===== hdl/ole_if.sv =====
// ----------------------------------------------------------------------------
// ole_if
// Valid/ready channels for list requests and list responses.
// ----------------------------------------------------------------------------
interface ole_req_if;
    logic                               valid;
    logic                               ready;
    logic [ole_pkg::CMD_W-1:0]          cmd;
    logic signed [ole_pkg::VALUE_W-1:0] value;
    logic [ole_pkg::POS_W-1:0]          position;

    modport source (output valid, cmd, value, position, input ready);
    modport sink   (input valid, cmd, value, position, output ready);
endinterface

interface ole_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [ole_pkg::STATUS_W-1:0]       status;
    logic signed [ole_pkg::VALUE_W-1:0] removed_value;
    logic [ole_pkg::COUNT_W-1:0]        entry_count;

    modport source (output valid, status, removed_value, entry_count, input ready);
    modport sink   (input valid, status, removed_value, entry_count, output ready);
endinterface

// ===== hdl/ole_ram.sv =====
// ----------------------------------------------------------------------------
// ole_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ole_addr.sv =====
// ----------------------------------------------------------------------------
// ole_addr
// Shared address unit: maps a logical list slot to a circular RAM address.
// ----------------------------------------------------------------------------
module ole_addr #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
    input  logic [$clog2(CAPACITY)-1:0] base,
    input  logic [$clog2(CAPACITY)-1:0] offset,
    output logic [$clog2(CAPACITY)-1:0] addr
);

    localparam int IDX_W = $clog2(CAPACITY);

    logic [IDX_W:0] sum;

    // add, then wrap once (both operands are below CAPACITY)
    always_comb
    begin
        sum = {1'b0, base} + {1'b0, offset};
        if (sum >= (IDX_W+1)'(CAPACITY))
        begin
            sum = sum - (IDX_W+1)'(CAPACITY);
        end
        addr = sum[IDX_W-1:0];
    end

endmodule

// ===== hdl/ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine
// Bounded double-ended list with delete-last and positional delete.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one request word (cmd, value, position); rsp channel
//   returns one response word (status, removed_value, entry_count) per request.
//   Entries sit in a circular RAM with a head pointer, so both inserts and
//   delete-last finish without moving data. A positional delete reads the
//   removed entry and then moves every later entry down one slot, one read
//   and one write per entry through the single RAM port pair and the shared
//   address adder.
//   The response is registered; the engine takes the next request while an
//   earlier response still waits. A stalled receiver only holds the engine
//   at the end of the following request, until the output slot frees up.
//   Reset empties the list; RAM contents are left as they are and are never
//   read before written.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    ole_req_if.sink    req,
    ole_rsp_if.source  rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > ole_pkg::POS_W) ? CNT_W : ole_pkg::POS_W;
    localparam int VW    = ole_pkg::VALUE_W;
    localparam int OCW   = ole_pkg::COUNT_W;

    ole_pkg::state_t  state_reg, state_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    ole_pkg::status_t status_reg, status_next;
    logic [VW-1:0]    removed_reg, removed_next;

    logic                 out_valid_reg, out_valid_next;
    ole_pkg::status_t     out_status_reg, out_status_next;
    logic [VW-1:0]        out_removed_reg, out_removed_next;
    logic [OCW-1:0]       out_count_reg, out_count_next;

    // request decode
    ole_pkg::cmd_t    cmd;
    ole_pkg::status_t req_status;
    logic             accept;
    logic             full;
    logic             empty;
    logic             is_delete;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] len_ext;
    logic [IDX_W-1:0] del_idx;
    logic             out_free;

    // RAM and address unit
    logic             ram_we;
    logic             ram_re;
    logic [VW-1:0]    ram_wdata;
    logic [VW-1:0]    ram_rdata;
    logic [IDX_W-1:0] addr_off;
    logic [IDX_W-1:0] addr;
    logic [CNT_W+OCW-1:0] cnt_wide;

    assign cmd      = ole_pkg::cmd_t'(req.cmd);
    assign accept   = req.valid && req.ready;
    assign full     = (len_reg >= CNT_W'(CAPACITY));
    assign empty    = (len_reg == '0);
    assign pos_ext  = CMP_W'(req.position);
    assign len_ext  = CMP_W'(len_reg);
    assign is_delete = (cmd == ole_pkg::CMD_DEL_LAST) || (cmd == ole_pkg::CMD_DEL_POS);
    assign out_free = !out_valid_reg || rsp.ready;

    // request status and delete slot
    always_comb
    begin
        req_status = ole_pkg::ST_OK;
        del_idx    = IDX_W'(len_reg - CNT_W'(1));
        case (cmd)
            ole_pkg::CMD_INS_FRONT,
            ole_pkg::CMD_INS_END:
            begin
                if (full)
                begin
                    req_status = ole_pkg::ST_FULL;
                end
            end
            ole_pkg::CMD_DEL_LAST:
            begin
                if (empty)
                begin
                    req_status = ole_pkg::ST_EMPTY;
                end
            end
            ole_pkg::CMD_DEL_POS:
            begin
                del_idx = IDX_W'(pos_ext - CMP_W'(2));
                if (empty)
                begin
                    req_status = ole_pkg::ST_EMPTY;
                end
                else if (pos_ext <= CMP_W'(1))
                begin
                    req_status = ole_pkg::ST_SMALL;
                end
                else if (pos_ext > len_ext)
                begin
                    req_status = ole_pkg::ST_BEYOND;
                end
            end
            default:
            begin
                req_status = ole_pkg::ST_OK;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ole_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (is_delete && (req_status == ole_pkg::ST_OK))
                    begin
                        state_next = ole_pkg::S_READ;
                    end
                    else
                    begin
                        state_next = ole_pkg::S_FINISH;
                    end
                end
            end
            ole_pkg::S_READ:
            begin
                state_next = ole_pkg::S_TAKE;
            end
            ole_pkg::S_TAKE:
            begin
                // len_reg still holds the count before the delete here
                if ((CNT_W'(idx_reg) + CNT_W'(1)) < len_reg)
                begin
                    state_next = ole_pkg::S_SHIFT_RD;
                end
                else
                begin
                    state_next = ole_pkg::S_FINISH;
                end
            end
            ole_pkg::S_SHIFT_RD:
            begin
                state_next = ole_pkg::S_SHIFT_WR;
            end
            ole_pkg::S_SHIFT_WR:
            begin
                // len_reg holds the count after the delete here
                if ((CNT_W'(idx_reg) + CNT_W'(1)) < len_reg)
                begin
                    state_next = ole_pkg::S_SHIFT_RD;
                end
                else
                begin
                    state_next = ole_pkg::S_FINISH;
                end
            end
            ole_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ole_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ole_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        req.ready     = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_wdata     = ram_rdata;
        addr_off      = idx_reg;
        head_next     = head_reg;
        len_next      = len_reg;
        idx_next      = idx_reg;
        status_next   = status_reg;
        removed_next  = removed_reg;

        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_removed_next = out_removed_reg;
        out_count_next   = out_count_reg;

        case (state_reg)
            ole_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                addr_off  = (cmd == ole_pkg::CMD_INS_FRONT) ? IDX_W'(CAPACITY - 1)
                                                            : IDX_W'(len_reg);
                ram_wdata = req.value;
                if (accept)
                begin
                    status_next  = req_status;
                    removed_next = '0;
                    idx_next     = del_idx;
                    if (!is_delete && (req_status == ole_pkg::ST_OK))
                    begin
                        ram_we   = 1'b1;
                        len_next = len_reg + CNT_W'(1);
                        if (cmd == ole_pkg::CMD_INS_FRONT)
                        begin
                            head_next = addr;
                        end
                    end
                end
            end
            ole_pkg::S_READ:
            begin
                ram_re = 1'b1;
            end
            ole_pkg::S_TAKE:
            begin
                removed_next = ram_rdata;
                len_next     = len_reg - CNT_W'(1);
            end
            ole_pkg::S_SHIFT_RD:
            begin
                addr_off = idx_reg + IDX_W'(1);
                ram_re   = 1'b1;
            end
            ole_pkg::S_SHIFT_WR:
            begin
                ram_we   = 1'b1;
                idx_next = idx_reg + IDX_W'(1);
            end
            ole_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = status_reg;
                    out_removed_next = removed_reg;
                    out_count_next   = cnt_wide[OCW-1:0];
                end
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign cnt_wide = {{OCW{1'b0}}, len_reg};

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ole_pkg::S_IDLE;
            head_reg      <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        status_reg      <= status_next;
        removed_reg     <= removed_next;
        out_status_reg  <= out_status_next;
        out_removed_reg <= out_removed_next;
        out_count_reg   <= out_count_next;
    end

    // shared slot-to-address unit
    ole_addr #(
        .CAPACITY (CAPACITY)
    ) u_addr (
        .base   (head_reg),
        .offset (addr_off),
        .addr   (addr)
    );

    // list storage
    ole_ram #(
        .WIDTH (VW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    // response channel
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.removed_value = out_removed_reg;
    assign rsp.entry_count   = out_count_reg;

endmodule

// ===== hdl/ole_checker.sv =====
// ----------------------------------------------------------------------------
// ole_checker
// Port-level checks of the ordered list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ole_checker #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               req_valid,
    input logic                               req_ready,
    input logic                               rsp_valid,
    input logic                               rsp_ready,
    input logic [ole_pkg::STATUS_W-1:0]       rsp_status,
    input logic signed [ole_pkg::VALUE_W-1:0] rsp_removed_value,
    input logic [ole_pkg::COUNT_W-1:0]        rsp_entry_count
);

    // a stalled response word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_removed_value) && $stable(rsp_entry_count))
        else $error("response word changed while stalled");

    // a failed request removes nothing
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ole_pkg::ST_OK) |-> rsp_removed_value == '0)
        else $error("nonzero removed value on failed request");

    // full report comes only with a full list
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ole_pkg::ST_FULL)
            |-> rsp_entry_count == ole_pkg::COUNT_W'(CAPACITY))
        else $error("full status with list not full");

    // empty report comes only with an empty list
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == ole_pkg::ST_EMPTY) |-> rsp_entry_count == '0)
        else $error("empty status with entries present");

    // a request is never answered in the cycle right after it is taken
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("response appeared too early");

endmodule

bind ordered_list_engine ole_checker #(
    .CAPACITY (CAPACITY)
) u_ole_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_removed_value (rsp.removed_value),
    .rsp_entry_count   (rsp.entry_count)
);

// ===== test/ordered_list_engine_test.sv =====
// ----------------------------------------------------------------------------
// ordered_list_engine_test
// Self-checking bench for the ordered list engine. A queue-based list model
// predicts status, removed word and entry count for every request; responses
// are checked in order. Directed tests cover the empty, full and position
// error cases, then random traffic runs with bursts of idling on both
// channels, and the run ends with a back-to-back stretch.
// ----------------------------------------------------------------------------
module ordered_list_engine_test;

    localparam int CAPACITY       = ole_pkg::CAPACITY_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;

    // One predicted response word
    typedef struct packed {
        ole_pkg::status_t                   status;
        logic signed [ole_pkg::VALUE_W-1:0] removed;
        logic [ole_pkg::COUNT_W-1:0]        count;
    } list_rsp_t;

    logic clk;
    logic rst_n;

    ole_req_if req ();
    ole_rsp_if rsp ();

    ordered_list_engine #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    // Model of the list contents, front at index 0
    logic signed [ole_pkg::VALUE_W-1:0] list_words[$];
    list_rsp_t                          expected_rsps[$];

    bit idle_on;
    int err_count;
    int words_sent;
    int words_checked;
    int status_seen[5];
    int peak_length;
    int quiet_cycles;
    int stall_left;

    always #1 clk = ~clk;

    // Apply one request to the list model and return the response it yields
    function automatic list_rsp_t apply_request(ole_pkg::cmd_t c,
                                                logic signed [ole_pkg::VALUE_W-1:0] v,
                                                logic [ole_pkg::POS_W-1:0] p);
        list_rsp_t r;
        r.status  = ole_pkg::ST_OK;
        r.removed = '0;
        case (c)
            ole_pkg::CMD_INS_FRONT:
            begin
                if (list_words.size() >= CAPACITY)
                    r.status = ole_pkg::ST_FULL;
                else
                    list_words.push_front(v);
            end
            ole_pkg::CMD_INS_END:
            begin
                if (list_words.size() >= CAPACITY)
                    r.status = ole_pkg::ST_FULL;
                else
                    list_words.push_back(v);
            end
            ole_pkg::CMD_DEL_LAST:
            begin
                if (list_words.size() == 0)
                    r.status = ole_pkg::ST_EMPTY;
                else
                    r.removed = list_words.pop_back();
            end
            default:
            begin
                // empty wins over any position check
                if (list_words.size() == 0)
                    r.status = ole_pkg::ST_EMPTY;
                else if (p <= 1)
                    r.status = ole_pkg::ST_SMALL;
                else if (int'(p) > list_words.size())
                    r.status = ole_pkg::ST_BEYOND;
                else
                begin
                    r.removed = list_words[p - 2];
                    list_words.delete(p - 2);
                end
            end
        endcase
        r.count = ole_pkg::COUNT_W'(list_words.size());
        if (list_words.size() > peak_length)
            peak_length = list_words.size();
        return r;
    endfunction

    // Send one request word; called right after a rising edge, returns at the
    // edge where the word was accepted with valid still high
    task automatic send_request(ole_pkg::cmd_t c, logic signed [ole_pkg::VALUE_W-1:0] v,
                                logic [ole_pkg::POS_W-1:0] p);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            req.valid    <= 1'b0;
            req.cmd      <= ole_pkg::CMD_W'($urandom_range(0, 3));
            req.value    <= ole_pkg::VALUE_W'($urandom);
            req.position <= ole_pkg::POS_W'($urandom_range(0, 255));
            repeat (gap) @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.cmd      <= c;
        req.value    <= v;
        req.position <= p;
        do
            @(posedge clk);
        while (!req.ready);
        expected_rsps.push_back(apply_request(c, v, p));
        words_sent++;
    endtask

    // Requests on an empty list
    task automatic test_empty_list();
        send_request(ole_pkg::CMD_DEL_LAST, 32'sh0, 8'd0);
        send_request(ole_pkg::CMD_DEL_POS, 32'sh7fff_ffff, 8'hff);
        send_request(ole_pkg::CMD_DEL_POS, -32'sd1, 8'd2);
    endtask

    // Fill to capacity from both ends with edge words, then insert into full
    task automatic test_fill_and_full();
        logic signed [ole_pkg::VALUE_W-1:0] edge_words[7];
        int i;
        edge_words = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1,
                       32'shaaaa_aaaa, 32'sh5555_5555, 32'sh1};
        for (i = 0; i < CAPACITY; i++)
            send_request((i % 2) ? ole_pkg::CMD_INS_FRONT : ole_pkg::CMD_INS_END,
                         edge_words[i % 7], 8'(i));
        send_request(ole_pkg::CMD_INS_FRONT, 32'sh1234_5678, 8'd0);
        send_request(ole_pkg::CMD_INS_END, 32'sh8000_0000, 8'd0);
    endtask

    // Position limits and the deletes at both ends of the valid range
    task automatic test_position_rules();
        send_request(ole_pkg::CMD_DEL_POS, 32'sh0, 8'd0);
        send_request(ole_pkg::CMD_DEL_POS, 32'sh0, 8'd1);
        send_request(ole_pkg::CMD_DEL_POS, 32'sh0, 8'(CAPACITY + 1));
        send_request(ole_pkg::CMD_DEL_POS, 32'sh0, 8'hff);
        send_request(ole_pkg::CMD_DEL_POS, 32'sh0, 8'd2);
        send_request(ole_pkg::CMD_DEL_POS, 32'sh0, 8'(list_words.size()));
        send_request(ole_pkg::CMD_DEL_POS, 32'sh0, 8'(list_words.size() + 1));
        send_request(ole_pkg::CMD_DEL_LAST, 32'sh0, 8'd0);
    endtask

    // Random traffic in phases that grow, shrink or churn the list, or send random fields
    task automatic test_random_traffic(input int n_items, input bit with_idle);
        int k;
        int len;
        int r;
        int mode;
        int grow_pct;
        ole_pkg::cmd_t c;
        logic signed [ole_pkg::VALUE_W-1:0] v;
        logic [ole_pkg::POS_W-1:0] p;
        mode = 0;
        for (k = 0; k < n_items; k++)
        begin
            if (k % 48 == 0)
            begin
                mode    = $urandom_range(0, 3);
                idle_on = with_idle && ($urandom_range(0, 9) < 7);
            end
            len = list_words.size();
            r   = $urandom_range(0, 99);
            grow_pct = (mode == 0) ? 75 : (mode == 1) ? 25 : 50;

            // value: mostly random, sometimes an edge word
            case ($urandom_range(0, 9))
                0:       v = 32'sh8000_0000;
                1:       v = 32'sh7fff_ffff;
                2:       v = -32'sd1;
                default: v = ole_pkg::VALUE_W'($urandom);
            endcase

            if (mode == 3)
            begin
                // noise: every field random
                c = ole_pkg::cmd_t'($urandom_range(0, 3));
                p = ole_pkg::POS_W'($urandom_range(0, 255));
            end
            else
            begin
                if (r < grow_pct)
                    c = $urandom_range(0, 1) ? ole_pkg::CMD_INS_FRONT : ole_pkg::CMD_INS_END;
                else
                    c = ($urandom_range(0, 99) < 35) ? ole_pkg::CMD_DEL_LAST
                                                     : ole_pkg::CMD_DEL_POS;
                case ($urandom_range(0, 9))
                    0:       p = ole_pkg::POS_W'($urandom_range(0, 255));
                    1:       p = ole_pkg::POS_W'($urandom_range(0, 1));
                    2:       p = ole_pkg::POS_W'($urandom_range(len + 1, 255));
                    default: p = ole_pkg::POS_W'((len >= 2) ? $urandom_range(2, len)
                                                            : $urandom_range(0, 3));
                endcase
            end
            send_request(c, v, p);
        end
    endtask

    // Receiver ready with random stall bursts
    initial
    begin
        rsp.ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || !idle_on)
            begin
                stall_left = 0;
                rsp.ready <= rst_n;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // Check each accepted response word against the oldest prediction
    always @(posedge clk)
    begin
        list_rsp_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            words_checked++;
            if (rsp.status <= ole_pkg::ST_FULL)
                status_seen[rsp.status]++;
            if (expected_rsps.size() == 0)
            begin
                $display("%0t: response with none pending: status %0d removed %0d count %0d",
                         $time, rsp.status, rsp.removed_value, rsp.entry_count);
                err_count++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                if (rsp.status !== want.status)
                begin
                    $display("%0t: status expected %0d, actual %0d",
                             $time, want.status, rsp.status);
                    err_count++;
                end
                if (rsp.removed_value !== want.removed)
                begin
                    $display("%0t: removed_value expected %0d, actual %0d",
                             $time, want.removed, rsp.removed_value);
                    err_count++;
                end
                if (rsp.entry_count !== want.count)
                begin
                    $display("%0t: entry_count expected %0d, actual %0d",
                             $time, want.count, rsp.entry_count);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: timeout, no word accepted for %0d cycles, %0d responses pending",
                     $time, quiet_cycles, expected_rsps.size());
            $display("status: fail");
            $finish;
        end
    end

    // Test sequence
    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        req.valid    = 1'b0;
        req.cmd      = '0;
        req.value    = '0;
        req.position = '0;
        idle_on      = 1'b0;
        quiet_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_list();
        test_fill_and_full();
        test_position_rules();
        idle_on = 1'b1;
        test_random_traffic(1700, 1'b1);
        idle_on = 1'b0;
        test_random_traffic(250, 1'b0);
        req.valid <= 1'b0;

        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests, %0d responses checked, peak list length %0d",
                 words_sent, words_checked, peak_length);
        $display("outcomes: ok %0d, empty %0d, too small %0d, beyond %0d, full %0d",
                 status_seen[ole_pkg::ST_OK], status_seen[ole_pkg::ST_EMPTY],
                 status_seen[ole_pkg::ST_SMALL], status_seen[ole_pkg::ST_BEYOND],
                 status_seen[ole_pkg::ST_FULL]);
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
